// ===== hdl/bfiq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bfiq_pkg;

    localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2 = 32'h1b873593;
    localparam logic [31:0] MIX_N  = 32'he6546b64;
    localparam logic [31:0] FMIX1  = 32'h85ebca6b;
    localparam logic [31:0] FMIX2  = 32'hc2b2ae35;

    localparam logic [0:0] ACT_INSERT = 1'b0;
    localparam logic [0:0] ACT_QUERY  = 1'b1;

    localparam logic [0:0] REG_BIT_COUNT = 1'b0;
    localparam logic [0:0] REG_PROBE_CNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCR1,
        ST_SCR2,
        ST_SCR3,
        ST_MIX,
        ST_FIN,
        ST_FM1,
        ST_FM2,
        ST_FM3,
        ST_MOD,
        ST_RD,
        ST_CHK,
        ST_CLEAR,
        ST_OUT
    } t_state;

    // Probe request from the hash engine to the bit store.
    typedef struct packed {
        logic        valid;
        logic        write;
        logic [23:0] index;
    } t_probe;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] d;
        d = {v, v} << r;
        return d[63:32];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bfiq_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bfiq_store
    import bfiq_pkg::*;
#(
    parameter int MAX_BITS = 65536
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_probe       i_probe,
    output logic         o_bit,
    output logic         o_ready
);
    localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

    logic r_mem [MAX_BITS];
    logic [AW:0] r_clr;
    logic r_clearing;

    assign o_ready = !r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == (AW + 1)'(MAX_BITS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Single port: the clearing sweep owns the port until it ends.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr[AW-1:0]] <= 1'b0;
        end else if (i_probe.valid && i_probe.write) begin
            r_mem[i_probe.index[AW-1:0]] <= 1'b1;
        end
        o_bit <= r_mem[i_probe.index[AW-1:0]];
    end
endmodule
`default_nettype wire

// ===== hdl/bfiq_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bfiq_hash
    import bfiq_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire  [31:0]  i_word,
    input  wire  [2:0]   i_bytes,
    input  wire          i_last,
    input  wire          i_action,
    input  wire  [16:0]  i_bit_count,
    input  wire  [3:0]   i_probe_cnt,
    input  wire          i_store_ready,
    input  wire          i_bit,
    output t_probe       o_probe,
    output logic         o_busy,
    output logic         o_done,
    output logic         o_found,
    output logic [31:0]  o_total,
    input  wire          i_out_taken
);
    localparam int HW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int IW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int MW = IW + 1;

    // Running hashes sit in a small memory, read-modify-written one seed a cycle.
    logic [31:0] r_hmem [MAX_HASHES];
    logic [31:0] r_hrd;
    t_state r_st, n_st;
    logic [HW:0] r_i;
    logic [HW:0] r_probes;
    logic [31:0] r_k, r_len, r_h, r_total;
    logic [2:0]  r_nb;
    logic        r_last, r_act, r_found, r_first;
    logic [MW-1:0] r_mod;
    logic [MW:0]   r_sh;
    logic [31:0] r_rem;

    logic [HW-1:0] w_idx;
    logic [31:0] w_mask, w_mixed, w_h13;
    logic [MW+31:0] w_diff;
    logic [2:0] w_nb;

    assign w_idx  = r_i[HW-1:0];
    assign w_nb   = (!i_last || i_bytes > 3'd4) ? 3'd4 : i_bytes;
    // An empty last word scrambles to zero and leaves the hashes unchanged.
    assign w_mask = (r_nb == 3'd0) ? 32'h00000000 :
                    (r_nb == 3'd1) ? 32'h000000ff :
                    (r_nb == 3'd2) ? 32'h0000ffff :
                    (r_nb == 3'd3) ? 32'h00ffffff : 32'hffffffff;
    assign w_h13   = rotl(r_hrd ^ r_k, 5'd13);
    assign w_mixed = (r_nb == 3'd4) ? (w_h13 * 32'd5 + MIX_N) : (r_hrd ^ r_k);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (i_start) n_st = ST_SCR1;
            ST_SCR1:  n_st = ST_SCR2;
            ST_SCR2:  n_st = ST_SCR3;
            ST_SCR3:  n_st = ST_MIX;
            ST_MIX:   if (r_i == (HW + 1)'(MAX_HASHES)) n_st = r_last ? ST_FIN : ST_IDLE;
            ST_FIN:   n_st = ST_FM1;
            ST_FM1:   n_st = ST_FM2;
            ST_FM2:   n_st = ST_FM3;
            ST_FM3:   n_st = ST_MOD;
            ST_MOD:   if (r_sh == '0) n_st = ST_RD;
            ST_RD:    if (i_store_ready) n_st = ST_CHK;
            ST_CHK:   n_st = (r_i + 1'b1 == r_probes) ? ST_CLEAR : ST_FIN;
            // The reseed pass after reset ends without a result.
            ST_CLEAR: if (r_i == (HW + 1)'(MAX_HASHES - 1)) n_st = r_first ? ST_IDLE : ST_OUT;
            ST_OUT:   if (i_out_taken) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_probe.valid = (r_st == ST_RD) && i_store_ready;
        o_probe.write = (r_act == ACT_INSERT);
        o_probe.index = 24'(r_rem[IW-1:0]);
        o_busy  = (r_st != ST_IDLE);
        o_done  = (r_st == ST_OUT);
        o_found = r_found;
        o_total = r_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLEAR;
            r_total <= '0;
            r_len   <= '0;
            r_first <= 1'b1;
            r_i     <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: begin
                    r_i <= '0;
                    if (i_start) begin
                        r_k    <= i_word;
                        r_nb   <= w_nb;
                        r_last <= i_last;
                        r_act  <= i_action;
                        r_len  <= r_len + 32'(w_nb);
                    end
                end
                ST_SCR1: r_k <= (r_k & w_mask) * MIX_C1;
                ST_SCR2: r_k <= rotl(r_k, 5'd15);
                ST_SCR3: r_k <= r_k * MIX_C2;
                ST_MIX: begin
                    // The read of seed r_i-1 lands now; r_i stays one ahead.
                    if (r_i == (HW + 1)'(MAX_HASHES)) begin
                        r_i      <= '0;
                        r_found  <= 1'b1;
                        r_probes <= (i_probe_cnt == 4'd0) ? (HW + 1)'(1) :
                                    (32'(i_probe_cnt) > 32'(MAX_HASHES)) ?
                                    (HW + 1)'(MAX_HASHES) : (HW + 1)'(i_probe_cnt);
                        r_mod <= (i_bit_count == 17'd0) ? MW'(1) :
                                 (32'(i_bit_count) > 32'(MAX_BITS)) ?
                                 MW'(MAX_BITS) : MW'(i_bit_count);
                        if (r_last && r_act == ACT_INSERT && r_total != 32'hffffffff) begin
                            r_total <= r_total + 1'b1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_FIN:  r_h <= r_hrd ^ r_len;
                ST_FM1:  r_h <= (r_h ^ (r_h >> 16)) * FMIX1;
                ST_FM2:  r_h <= (r_h ^ (r_h >> 13)) * FMIX2;
                ST_FM3: begin
                    r_rem <= r_h ^ (r_h >> 16);
                    r_sh  <= (MW + 1)'(32);
                end
                ST_MOD: begin
                    // Restoring reduction, one bit of the shifted modulus a cycle.
                    if (r_sh != '0) begin
                        if ({{MW{1'b0}}, r_rem} >= w_diff) r_rem <= 32'(({{MW{1'b0}}, r_rem} - w_diff));
                        r_sh <= r_sh - 1'b1;
                    end
                end
                ST_CHK: begin
                    if (r_act == ACT_QUERY && !i_bit) r_found <= 1'b0;
                    r_i <= (n_st == ST_CLEAR) ? '0 : r_i + 1'b1;
                end
                ST_CLEAR: begin
                    r_i   <= (n_st != ST_CLEAR) ? '0 : r_i + 1'b1;
                    r_len <= '0;
                    if (n_st != ST_CLEAR) r_first <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign w_diff = (MW + 32)'(r_mod) << (r_sh - 1'b1);

    // Hash memory port: read address and write-back.
    logic [HW-1:0] w_raddr;
    always_comb begin
        w_raddr = w_idx;
        if (r_st == ST_CHK) w_raddr = HW'(r_i + 1'b1);
        if (r_st == ST_MIX && r_i == (HW + 1)'(MAX_HASHES)) w_raddr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_MIX && r_i != '0) begin
            r_hmem[HW'(r_i - 1'b1)] <= w_mixed;
        end else if (r_st == ST_CLEAR) begin
            r_hmem[w_idx] <= 32'(r_i);
        end
        r_hrd <= r_hmem[w_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/bloom_filter_insert_query.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel     Dir  Payload
// s_axis      in   tdata {word_bytes, key_word}, tuser action, tlast last
// m_axis      out  tdata {insert_total}, tuser found
// APB         in   bit_count at 0x0, probe count at 0x4
// A key word holds the block after its transaction through the scramble steps ST_SCR1,
// ST_SCR2 and ST_SCR3 and a pass over the hash memory in ST_MIX, and the next word is
// taken only once the block is idle again. The last word adds per probe the finalize
// steps, the modulo reduction and the store read, then a reseed of the hash memory.
// Reset runs a clearing sweep over all MAX_BITS bits; no item is taken meanwhile.
// A waiting result holds the block until the m_axis side takes it.
module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // key_word[31:0], word_bytes[34:32], zeros
    input  wire  [0:0]  s_axis_tuser,   // action
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // insert_total
    output logic [0:0]  m_axis_tuser,   // found
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [16:0] r_bit_count;
    logic [3:0]  r_probe_cnt;
    t_probe w_probe;
    logic w_bit, w_sready, w_busy, w_done, w_found;
    logic [31:0] w_total;
    logic w_start;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROBE_CNT) ? 32'(r_probe_cnt) : 32'(r_bit_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= 17'd65536;
            r_probe_cnt <= 4'd4;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_BIT_COUNT) r_bit_count <= pwdata[16:0];
            else r_probe_cnt <= pwdata[3:0];
        end
    end

    assign s_axis_tready = !w_busy && w_sready;
    assign w_start = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = w_done;
    assign m_axis_tdata  = w_total;
    assign m_axis_tuser  = w_found;

    bfiq_store #(.MAX_BITS(MAX_BITS)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_probe (w_probe),
        .o_bit   (w_bit),
        .o_ready (w_sready)
    );

    bfiq_hash #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_hash (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_word        (s_axis_tdata[31:0]),
        .i_bytes       (s_axis_tdata[34:32]),
        .i_last        (s_axis_tlast),
        .i_action      (s_axis_tuser[0]),
        .i_bit_count   (r_bit_count),
        .i_probe_cnt   (r_probe_cnt),
        .i_store_ready (w_sready),
        .i_bit         (w_bit),
        .o_probe       (w_probe),
        .o_busy        (w_busy),
        .o_done        (w_done),
        .o_found       (w_found),
        .o_total       (w_total),
        .i_out_taken   (m_axis_tready)
    );
endmodule
`default_nettype wire

// ===== hdl/bfiq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bfiq_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result repeated");
endmodule

bind bloom_filter_insert_query bfiq_checker u_chk (.*);
`default_nettype wire
